[sv/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the buddy page allocator
// function and status codes, field widths and the page size
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  // byte offset bits within one page
  localparam int PageBytesLog = 12;
  // widths of the beat fields
  localparam int AddrW  = 64;
  localparam int RankW  = 5;
  localparam int ValW   = 11;

  // request function carried in tuser
  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_COUNT = 2'd3
  } func_e;

  // result status carried in tuser
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INVALID  = 2'd1,
    STAT_NO_SPACE = 2'd2
  } status_e;

endpackage

`default_nettype wire

[sv/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram: simple dual port memory
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/buddy_page_allocator.sv]
// allocation searches upward over the ranks, then splits down rank by rank;
//   free merges level by level, walking the free list to unlink each buddy
// throughput: one request at a time, the next is taken once the current one
//   has reached the output register; the list walk and the bit memory set it
// reset: a clearing pass over every page address sweeps the rank and pair memories,
//   no request is taken meanwhile; configuration writes are taken at any time
// ----------------------------------------------------------------------------
// buddy_page_allocator: buddy page allocator top level
// per-rank free lists, pair bits and page ranks under one sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator #(
  parameter int PAGE_COUNT = 1024,
  parameter int MAX_RANK   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: base_address
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [63:0] cfg_data_i,
  // request beats
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // rank[4:0], page_address[68:5], zero fill
  input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
  // result beats
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,  // block_address[63:0], result_value[74:64]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);
  import bpa_pkg::*;

  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int PAIRS  = PAGE_COUNT / 2;
  localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CNT_W  = PAGE_W + 1;
  localparam int RIDX_W = $clog2(MAX_RANK);
  localparam int LOG_PC = $clog2(PAGE_COUNT + 1);
  localparam int TOP    = (MAX_RANK < LOG_PC) ? MAX_RANK : LOG_PC;

  typedef enum logic [17:0] {
    ST_CLEAR     = 18'h00001,
    ST_IDLE      = 18'h00002,
    ST_SRCH      = 18'h00004,
    ST_POP_RD    = 18'h00008,
    ST_POP_WR    = 18'h00010,
    ST_TGL_RD    = 18'h00020,
    ST_TGL_WR    = 18'h00040,
    ST_SPLIT     = 18'h00080,
    ST_ALLOC_FIN = 18'h00100,
    ST_DEC       = 18'h00200,
    ST_CHK       = 18'h00400,
    ST_RK_WT     = 18'h00800,
    ST_POST_TGL  = 18'h01000,
    ST_UL_RD     = 18'h02000,
    ST_UL_CHK    = 18'h04000,
    ST_MERGE_UP  = 18'h08000,
    ST_PUSH      = 18'h10000,
    ST_FIN       = 18'h20000
  } state_e;

  state_e            state_q, state_d, ret_q, ret_d;
  logic [63:0]       base_q;
  func_e             func_q, func_d;
  logic [RankW-1:0]  rank_q, rank_d, r_q, r_d;
  logic [AddrW-1:0]  addr_q, addr_d, blk_q, blk_d;
  logic [AddrW:0]    diff_q, diff_d;
  logic [PAGE_W-1:0] pg_q, pg_d, tp_q, tp_d, tgt_q, tgt_d;
  logic [PAGE_W-1:0] cur_q, cur_d, prev_q, prev_d, clr_q, clr_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic              nb_q, nb_d;
  status_e           status_q, status_d, ostat_q, ostat_d;
  logic [ValW-1:0]   val_q, val_d, oval_q, oval_d;
  logic [AddrW-1:0]  oblk_q, oblk_d;
  logic              mvalid_q, mvalid_d;
  logic [PAGE_W-1:0] head_q [MAX_RANK];
  logic [PAGE_W-1:0] head_d [MAX_RANK];
  logic [CNT_W-1:0]  cnt_q [MAX_RANK];
  logic [CNT_W-1:0]  cnt_d [MAX_RANK];

  // memory ports
  logic              ln_we, ln_re, ar_we, ar_re, pr_we, pr_re;
  logic [PAGE_W-1:0] ln_waddr, ln_wdata, ln_raddr, ln_rdata;
  logic [PAGE_W-1:0] ar_waddr, ar_raddr;
  logic [RankW-1:0]  ar_wdata, ar_rdata;
  logic [PAIR_W-1:0] pr_waddr, pr_raddr;
  logic [MAX_RANK-1:0] pr_wdata, pr_rdata;

  // helpers on the current rank
  logic [RIDX_W-1:0] ri;
  logic [PAGE_W-1:0] size_w, half_w, psh;
  logic [PAGE_W:0]   pex, pred;
  logic [PAIR_W-1:0] pidx;
  logic [RankW-1:0]  tz;
  logic [15:0]       pgx;

  assign ri     = RIDX_W'(r_q - 5'd1);
  assign size_w = PAGE_W'(32'd1 << (r_q - 5'd1));
  assign half_w = PAGE_W'(32'd1 << (r_q - 5'd2));
  assign psh    = tp_q >> r_q;
  assign pex    = {1'b0, psh};
  assign pred   = (pex >= (PAGE_W+1)'(PAIRS)) ? pex - (PAGE_W+1)'(PAIRS) : pex;
  assign pidx   = PAIR_W'(pred);
  assign pgx    = 16'(pg_q);

  // trailing zero rank of an unallocated page
  always_comb begin
    tz = RankW'(MAX_RANK);
    for (int k = MAX_RANK - 2; k >= 0; k--) begin
      if (pgx[k]) tz = RankW'(k + 1);
    end
  end

  bpa_ram #(.DEPTH(PAGE_COUNT), .WIDTH(PAGE_W)) u_link (
    .clk_i, .we_i(ln_we), .waddr_i(ln_waddr), .wdata_i(ln_wdata),
    .re_i(ln_re), .raddr_i(ln_raddr), .rdata_o(ln_rdata)
  );

  bpa_ram #(.DEPTH(PAGE_COUNT), .WIDTH(RankW)) u_rank (
    .clk_i, .we_i(ar_we), .waddr_i(ar_waddr), .wdata_i(ar_wdata),
    .re_i(ar_re), .raddr_i(ar_raddr), .rdata_o(ar_rdata)
  );

  bpa_ram #(.DEPTH(PAIRS), .WIDTH(MAX_RANK)) u_pair (
    .clk_i, .we_i(pr_we), .waddr_i(pr_waddr), .wdata_i(pr_wdata),
    .re_i(pr_re), .raddr_i(pr_raddr), .rdata_o(pr_rdata)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    func_d   = func_q;
    rank_d   = rank_q;
    r_d      = r_q;
    addr_d   = addr_q;
    blk_d    = blk_q;
    diff_d   = diff_q;
    pg_d     = pg_q;
    tp_d     = tp_q;
    tgt_d    = tgt_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    clr_d    = clr_q;
    k_d      = k_q;
    nb_d     = nb_q;
    status_d = status_q;
    val_d    = val_q;
    ostat_d  = ostat_q;
    oval_d   = oval_q;
    oblk_d   = oblk_q;
    mvalid_d = mvalid_q && !m_axis_tready;
    head_d   = head_q;
    cnt_d    = cnt_q;
    ln_we    = 1'b0;
    ln_waddr = pg_q;
    ln_wdata = head_q[ri];
    ln_re    = 1'b0;
    ln_raddr = pg_q;
    ar_we    = 1'b0;
    ar_waddr = pg_q;
    ar_wdata = '0;
    ar_re    = 1'b0;
    ar_raddr = pg_q;
    pr_we    = 1'b0;
    pr_waddr = pidx;
    pr_wdata = pr_rdata ^ (MAX_RANK'(1) << ri);
    pr_re    = 1'b0;
    pr_raddr = pidx;

    unique case (state_q)
      ST_CLEAR: begin
        ar_we    = 1'b1;
        ar_waddr = clr_q;
        if ((CNT_W)'(clr_q) < (CNT_W)'(PAIRS)) begin
          pr_we    = 1'b1;
          pr_waddr = PAIR_W'(clr_q);
          pr_wdata = '0;
        end
        if (clr_q == PAGE_W'(PAGE_COUNT - 1)) state_d = ST_IDLE;
        else clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          func_d   = func_e'(s_axis_tuser);
          rank_d   = s_axis_tdata[4:0];
          r_d      = s_axis_tdata[4:0];
          addr_d   = s_axis_tdata[68:5];
          status_d = STAT_OK;
          blk_d    = '0;
          val_d    = '0;
          unique case (func_e'(s_axis_tuser))
            FUNC_ALLOC: begin
              if (s_axis_tdata[4:0] == '0 || s_axis_tdata[4:0] > RankW'(MAX_RANK)) begin
                status_d = STAT_INVALID;
                state_d  = ST_FIN;
              end else begin
                state_d = ST_SRCH;
              end
            end
            FUNC_FREE, FUNC_QUERY: state_d = ST_DEC;
            FUNC_COUNT: begin
              if (s_axis_tdata[4:0] == '0 || s_axis_tdata[4:0] > RankW'(MAX_RANK)) begin
                status_d = STAT_INVALID;
              end else begin
                val_d = ValW'(cnt_q[RIDX_W'(s_axis_tdata[4:0] - 5'd1)]);
              end
              state_d = ST_FIN;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      // look upward for the first rank with a free block
      ST_SRCH: begin
        if (cnt_q[ri] != '0) begin
          pg_d    = head_q[ri];
          state_d = ST_POP_RD;
        end else if (r_q == RankW'(MAX_RANK)) begin
          status_d = STAT_NO_SPACE;
          state_d  = ST_FIN;
        end else begin
          r_d = r_q + 1'b1;
        end
      end
      ST_POP_RD: begin
        ln_re   = 1'b1;
        state_d = ST_POP_WR;
      end
      ST_POP_WR: begin
        head_d[ri] = ln_rdata;
        cnt_d[ri]  = cnt_q[ri] - 1'b1;
        tp_d       = pg_q;
        ret_d      = ST_SPLIT;
        state_d    = ST_TGL_RD;
      end
      // pair bit read, flip and write back
      ST_TGL_RD: begin
        pr_re   = 1'b1;
        state_d = ST_TGL_WR;
      end
      ST_TGL_WR: begin
        pr_we   = 1'b1;
        nb_d    = ~pr_rdata[ri];
        state_d = ret_q;
      end
      // push upper halves down to the requested rank
      ST_SPLIT: begin
        if (r_q == rank_q) begin
          ar_we    = 1'b1;
          ar_wdata = rank_q;
          state_d  = ST_ALLOC_FIN;
        end else begin
          ln_we                      = 1'b1;
          ln_waddr                   = pg_q + half_w;
          ln_wdata                   = head_q[RIDX_W'(r_q - 5'd2)];
          head_d[RIDX_W'(r_q - 5'd2)] = pg_q + half_w;
          cnt_d[RIDX_W'(r_q - 5'd2)]  = cnt_q[RIDX_W'(r_q - 5'd2)] + 1'b1;
          r_d                        = r_q - 1'b1;
          tp_d                       = pg_q + half_w;
          ret_d                      = ST_SPLIT;
          state_d                    = ST_TGL_RD;
        end
      end
      ST_ALLOC_FIN: begin
        blk_d   = base_q + {{(AddrW - PageBytesLog - PAGE_W){1'b0}}, pg_q, {PageBytesLog{1'b0}}};
        state_d = ST_FIN;
      end
      // address decode: subtract the base, then check the range
      ST_DEC: begin
        diff_d  = {1'b0, addr_q} - {1'b0, base_q};
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (diff_q[AddrW] || diff_q[AddrW-1:PageBytesLog+PAGE_W] != '0 ||
            (CNT_W)'(diff_q[PageBytesLog +: PAGE_W]) >= (CNT_W)'(PAGE_COUNT)) begin
          status_d = STAT_INVALID;
          state_d  = ST_FIN;
        end else begin
          pg_d     = diff_q[PageBytesLog +: PAGE_W];
          ar_re    = 1'b1;
          ar_raddr = diff_q[PageBytesLog +: PAGE_W];
          state_d  = ST_RK_WT;
        end
      end
      ST_RK_WT: begin
        if (func_q == FUNC_QUERY) begin
          val_d   = ValW'((ar_rdata != '0) ? ar_rdata : tz);
          state_d = ST_FIN;
        end else if (ar_rdata == '0) begin
          status_d = STAT_INVALID;
          state_d  = ST_FIN;
        end else begin
          ar_we   = 1'b1;
          r_d     = ar_rdata;
          tp_d    = pg_q;
          ret_d   = ST_POST_TGL;
          state_d = ST_TGL_RD;
        end
      end
      // merge decision after each toggle on the free path
      ST_POST_TGL: begin
        if (nb_q || r_q >= RankW'(TOP)) begin
          state_d = ST_PUSH;
        end else begin
          tgt_d = pg_q ^ size_w;
          cur_d = head_q[ri];
          k_d   = '0;
          state_d = (cnt_q[ri] == '0) ? ST_MERGE_UP : ST_UL_RD;
        end
      end
      // walk the list to unlink the buddy
      ST_UL_RD: begin
        ln_re    = 1'b1;
        ln_raddr = cur_q;
        state_d  = ST_UL_CHK;
      end
      ST_UL_CHK: begin
        if (cur_q == tgt_q) begin
          if (k_q == '0) begin
            head_d[ri] = ln_rdata;
          end else begin
            ln_we    = 1'b1;
            ln_waddr = prev_q;
            ln_wdata = ln_rdata;
          end
          cnt_d[ri] = cnt_q[ri] - 1'b1;
          state_d   = ST_MERGE_UP;
        end else begin
          prev_d  = cur_q;
          cur_d   = ln_rdata;
          k_d     = k_q + 1'b1;
          state_d = (k_q + 1'b1 == cnt_q[ri]) ? ST_MERGE_UP : ST_UL_RD;
        end
      end
      ST_MERGE_UP: begin
        pg_d    = pg_q & ~size_w;
        tp_d    = pg_q & ~size_w;
        r_d     = r_q + 1'b1;
        ret_d   = ST_POST_TGL;
        state_d = ST_TGL_RD;
      end
      ST_PUSH: begin
        ln_we      = 1'b1;
        head_d[ri] = pg_q;
        cnt_d[ri]  = cnt_q[ri] + 1'b1;
        state_d    = ST_FIN;
      end
      // hand the result to the output register
      ST_FIN: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          ostat_d  = status_q;
          oblk_d   = blk_q;
          oval_d   = val_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      mvalid_q <= 1'b0;
      base_q   <= '0;
      for (int i = 0; i < MAX_RANK; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= (i == TOP - 1) ? CNT_W'(1) : '0;
      end
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      mvalid_q <= mvalid_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      if (cfg_valid_i) base_q <= cfg_data_i;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    ret_q    <= ret_d;
    func_q   <= func_d;
    rank_q   <= rank_d;
    r_q      <= r_d;
    addr_q   <= addr_d;
    blk_q    <= blk_d;
    diff_q   <= diff_d;
    pg_q     <= pg_d;
    tp_q     <= tp_d;
    tgt_q    <= tgt_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    k_q      <= k_d;
    nb_q     <= nb_d;
    status_q <= status_d;
    val_q    <= val_d;
    ostat_q  <= ostat_d;
    oblk_q   <= oblk_d;
    oval_q   <= oval_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tdata  = {5'd0, oval_q, oblk_q};

  // checks
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UL_CHK) |-> (k_q < cnt_q[ri]))
    else $error("list walk past its count");
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mvalid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside finish");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != ST_IDLE))
    else $error("request beat not started");
  a_rank_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TGL_WR) |-> (r_q != '0 && r_q <= RankW'(MAX_RANK)))
    else $error("pair toggle on bad rank");

endmodule

`default_nettype wire

[bench/buddy_page_allocator_tb.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator_tb: self-checking bench for the buddy page allocator
// drives request beats with random gaps, predicts each result beat with a
// behavioural copy of the allocator state and compares field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int Pages   = 1024;
  localparam int MaxRank = 16;
  localparam int TopRank = 11;
  localparam int Pairs   = Pages / 2;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] blk;
    logic [10:0] val;
  } result_t;

  typedef struct {
    func_e       fn;
    logic [4:0]  rank;
    logic [63:0] addr;
    logic        typed;
    result_t     res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  buddy_page_allocator dut (.*);

  // clock, 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow allocator state
  logic [63:0] base_q;
  logic [9:0]  head_q [MaxRank];
  logic [9:0]  link_q [Pages];
  int          count_q [MaxRank];
  bit          pair_q [MaxRank*Pairs];
  logic [4:0]  prank_q [Pages];

  result_t pending_q[$];
  int      errors = 0;
  bit      calm = 0;
  bit      hold_off = 0;
  // pages currently allocated, used to steer free requests
  int      live_q[$];

  task automatic report_mismatch(input string what, input logic [79:0] got,
                                 input logic [79:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic bit flip_pair(int r, int pg);
    int s;
    s = (r - 1) * Pairs + ((pg >> r) % Pairs);
    pair_q[s] ^= 1'b1;
    return pair_q[s];
  endfunction

  function automatic void push_block(int r, int pg);
    link_q[pg % Pages] = head_q[r-1];
    head_q[r-1] = 10'(pg % Pages);
    count_q[r-1]++;
  endfunction

  function automatic void unlink_block(int r, int pg);
    int cur, prev;
    cur = head_q[r-1];
    prev = 0;
    for (int k = 0; k < count_q[r-1]; k++) begin
      if (cur == pg) begin
        if (k == 0) head_q[r-1] = link_q[cur];
        else link_q[prev] = link_q[cur];
        count_q[r-1]--;
        return;
      end
      prev = cur;
      cur = link_q[cur];
    end
  endfunction

  function automatic void reset_shadow();
    base_q = '0;
    for (int i = 0; i < MaxRank; i++) begin
      head_q[i] = '0;
      count_q[i] = 0;
    end
    for (int i = 0; i < Pages; i++) begin
      link_q[i] = '0;
      prank_q[i] = '0;
    end
    for (int i = 0; i < MaxRank*Pairs; i++) pair_q[i] = 1'b0;
    count_q[TopRank-1] = 1;
  endfunction

  function automatic bit page_of(logic [63:0] a, output int pg);
    logic [63:0] off;
    pg = 0;
    if (a < base_q) return 0;
    off = (a - base_q) >> PageBytesLog;
    if (off >= Pages) return 0;
    pg = int'(off);
    return 1;
  endfunction

  // predicted result of one request, updating the shadow state
  function automatic result_t allocator_step(func_e fn, logic [4:0] rank,
                                             logic [63:0] addr);
    result_t o;
    int pg, i, r;
    bit ok;
    o = '0;
    case (fn)
      FUNC_ALLOC: begin
        if (rank < 1 || rank > MaxRank) o.status = STAT_INVALID;
        else begin
          i = rank;
          while (i <= MaxRank && count_q[i-1] == 0) i++;
          if (i > MaxRank) o.status = STAT_NO_SPACE;
          else begin
            pg = head_q[i-1];
            head_q[i-1] = link_q[pg];
            count_q[i-1]--;
            void'(flip_pair(i, pg));
            for (int j = i - 1; j >= rank; j--) begin
              push_block(j, pg + (1 << (j - 1)));
              void'(flip_pair(j, pg + (1 << (j - 1))));
            end
            prank_q[pg] = rank;
            o.blk = base_q + (64'(pg) << PageBytesLog);
            live_q.push_back(pg);
          end
        end
      end
      FUNC_FREE: begin
        ok = page_of(addr, pg);
        if (!ok || prank_q[pg] == 0) o.status = STAT_INVALID;
        else begin
          r = prank_q[pg];
          prank_q[pg] = '0;
          for (int k = 0; k < live_q.size(); k++)
            if (live_q[k] == pg) begin
              live_q.delete(k);
              break;
            end
          if (r >= TopRank) void'(flip_pair(r, pg));
          else if (!flip_pair(r, pg)) begin
            forever begin
              unlink_block(r, pg ^ (1 << (r - 1)));
              pg &= ~(1 << (r - 1));
              r++;
              if (flip_pair(r, pg) || r >= TopRank) break;
            end
          end
          push_block(r, pg);
        end
      end
      FUNC_QUERY: begin
        ok = page_of(addr, pg);
        if (!ok) o.status = STAT_INVALID;
        else if (prank_q[pg] != 0) o.val = 11'(prank_q[pg]);
        else begin
          i = 0;
          while (i + 1 < MaxRank && ((pg >> i) & 1) == 0) i++;
          o.val = 11'(i + 1);
        end
      end
      default: begin
        if (rank < 1 || rank > MaxRank) o.status = STAT_INVALID;
        else o.val = count_q[rank-1][10:0];
      end
    endcase
    return o;
  endfunction

  // one request beat; typed rows check their own expectation too
  // the beat stays offered until the next call replaces or withdraws it
  task automatic send_request(func_e fn, logic [4:0] rank, logic [63:0] addr,
                              bit typed = 0, result_t want = '0);
    result_t p;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {3'b000, addr, rank};
    s_axis_tuser  <= fn;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = allocator_step(fn, rank, addr);
    if (typed && p != want) report_mismatch("typed row", 80'(p), 80'(want));
    pending_q.push_back(p);
    @(negedge clk_i);
  endtask

  task automatic write_base(logic [63:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    base_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // a random request, mostly well formed
  task automatic random_request();
    int k, pg;
    logic [63:0] a;
    k = $urandom_range(0, 99);
    a = base_q + (64'($urandom_range(0, Pages - 1)) << PageBytesLog)
        + 64'($urandom_range(0, 4095));
    if (k < 40) send_request(FUNC_ALLOC, 5'($urandom_range(1, 6)), rnd64());
    else if (k < 75 && live_q.size() != 0) begin
      pg = live_q[$urandom_range(0, live_q.size() - 1)];
      send_request(FUNC_FREE, 5'($urandom()),
                   base_q + (64'(pg) << PageBytesLog) + 64'($urandom_range(0, 4095)));
    end else if (k < 82) send_request(FUNC_QUERY, 5'($urandom()), a);
    else if (k < 90) send_request(FUNC_COUNT, 5'($urandom_range(0, 17)), rnd64());
    else if (k < 95) send_request(FUNC_FREE, 5'($urandom()), a);
    else send_request(func_e'($urandom_range(0, 3)), 5'($urandom()), rnd64());
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        gap = $urandom_range(1, 15);
        repeat (gap - 1) @(negedge clk_i);
      end else m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) report_mismatch("unexpected beat", m_axis_tdata, '0);
      else begin
        want = pending_q.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", 80'(m_axis_tuser), 80'(want.status));
        if (m_axis_tdata[63:0] != want.blk)
          report_mismatch("block_address", 80'(m_axis_tdata[63:0]), 80'(want.blk));
        if (m_axis_tdata[74:64] != want.val)
          report_mismatch("result_value", 80'(m_axis_tdata[74:64]), 80'(want.val));
        if (m_axis_tdata[79:75] != '0)
          report_mismatch("fill bits", m_axis_tdata, '0);
      end
    end
  end

  // overall time limit
  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    logic [63:0] bases[4];
    reset_shadow();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed rows: reset state, bad ranks, bounds, every function
    rows = '{
      '{FUNC_COUNT, 5'd11, 64'd0, 1, '{STAT_OK, 64'd0, 11'd1}},
      '{FUNC_COUNT, 5'd0, '1, 1, '{STAT_INVALID, 64'd0, 11'd0}},
      '{FUNC_COUNT, 5'd17, 64'd0, 1, '{STAT_INVALID, 64'd0, 11'd0}},
      '{FUNC_ALLOC, 5'd0, 64'd0, 1, '{STAT_INVALID, 64'd0, 11'd0}},
      '{FUNC_ALLOC, 5'd31, '1, 1, '{STAT_INVALID, 64'd0, 11'd0}},
      '{FUNC_QUERY, 5'd0, 64'd0, 1, '{STAT_OK, 64'd0, 11'd16}},
      '{FUNC_QUERY, 5'd0, 64'h400000, 1, '{STAT_INVALID, 64'd0, 11'd0}},
      '{FUNC_QUERY, 5'd0, 64'h3FFFFF, 1, '{STAT_OK, 64'd0, 11'd1}},
      '{FUNC_FREE, 5'd0, 64'd0, 1, '{STAT_INVALID, 64'd0, 11'd0}},
      '{FUNC_ALLOC, 5'd12, 64'd0, 1, '{STAT_NO_SPACE, 64'd0, 11'd0}},
      '{FUNC_ALLOC, 5'd16, 64'd0, 1, '{STAT_NO_SPACE, 64'd0, 11'd0}},
      '{FUNC_ALLOC, 5'd11, 64'd0, 1, '{STAT_OK, 64'd0, 11'd0}},
      '{FUNC_ALLOC, 5'd1, 64'd0, 1, '{STAT_NO_SPACE, 64'd0, 11'd0}},
      '{FUNC_FREE, 5'd0, 64'd0, 1, '{STAT_OK, 64'd0, 11'd0}},
      '{FUNC_ALLOC, 5'd1, 64'd0, 0, '0},
      '{FUNC_ALLOC, 5'd1, 64'd0, 0, '0},
      '{FUNC_QUERY, 5'd0, 64'h1000, 0, '0},
      '{FUNC_COUNT, 5'd1, 64'd0, 0, '0},
      '{FUNC_FREE, 5'd0, 64'h1FFF, 0, '0},
      '{FUNC_FREE, 5'd0, 64'h1000, 0, '0},
      '{FUNC_FREE, 5'd0, 64'h0, 0, '0},
      '{FUNC_COUNT, 5'd11, 64'd0, 0, '0}
    };
    foreach (rows[i]) send_request(rows[i].fn, rows[i].rank, rows[i].addr,
                                   rows[i].typed, rows[i].res);
    // random phases over several base addresses, extremes among them
    bases = '{64'hFFFF_FFFF_FFFF_F000, 64'h0000_0000_8000_0000, rnd64(), 64'd0};
    for (int ph = 0; ph < 4; ph++) begin
      write_base(bases[ph]);
      if (ph == 0) begin
        send_request(FUNC_ALLOC, 5'd1, 64'd0);
        send_request(FUNC_QUERY, 5'd0, 64'hFFFF_FFFF_FFFF_F000);
        send_request(FUNC_QUERY, 5'd0, 64'h0);
        send_request(FUNC_FREE, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      end
      if (ph == 1) hold_off = 1;
      if (ph == 3) calm = 1;
      repeat (430) random_request();
    end
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
